// ===== rtl/java_comment_stripper_macros.svh =====
// Assertion macros used by the asserting file, java_comment_stripper.sv.
`ifndef JAVA_COMMENT_STRIPPER_MACROS_SVH
`define JAVA_COMMENT_STRIPPER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define JCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/jcs_pkg.sv =====
package jcs_pkg;

	// Characters the scanner reacts to
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// Queue between scanner and result sequencer
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Scanner modes
	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_SLASH   = 3'd1,
		MODE_LINE    = 3'd2,
		MODE_BLOCK   = 3'd3,
		MODE_BSTAR   = 3'd4,
		MODE_LIT     = 3'd5,
		MODE_LIT_ESC = 3'd6
	} mode_t;

	// Results caused by one item: zero bytes (end marker), one or two bytes
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic       two;
		logic       has;
		logic       last;
	} grp_t;

endpackage

// ===== rtl/java_comment_stripper.sv =====
// An item's first result is registered into the queue when the item is accepted.
// One item per cycle in while the queue is not full, one result per cycle out while
// it is not empty; the result side sets the sustained rate when items release two bytes each.
// A four-entry queue of result groups decouples scanner and result sequencer.
// Reset (arst_n low, asynchronous): normal text mode, queue empty.
module java_comment_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_last,
	output logic       stream_end
);
	import jcs_pkg::*;
	`include "java_comment_stripper_macros.svh"

	grp_t         grp, head;
	logic         grp_push, deq, accept;
	logic [QAW:0] level;

	assign accept = push && !full;

	// Scanner
	jcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.grp_push (grp_push),
		.grp      (grp)
	);

	// Group queue
	jcs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (grp_push),
		.wdata  (grp),
		.pop    (deq),
		.rdata  (head),
		.full   (full),
		.empty  (empty),
		.level  (level)
	);

	// Result sequencer
	jcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (empty),
		.pop        (pop),
		.deq        (deq),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.run_last   (run_last),
		.stream_end (stream_end)
	);

	// Checks
	`JCS_ASSERT_IMP(a_level_bound, clk, arst_n, 1'b1, level <= (QAW+1)'(QDEPTH))
	`JCS_ASSERT_NXT(a_pair_follows, clk, arst_n, pop && !empty && !run_last, !empty && has_byte)
	`JCS_ASSERT_IMP(a_marker_form, clk, arst_n, !empty && !has_byte, stream_end && out_byte == 8'h00)

endmodule

// ===== rtl/jcs_front.sv =====
module jcs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output logic          grp_push,
	output jcs_pkg::grp_t grp
);
	import jcs_pkg::*;

	mode_t      mode_q, mode_nx;
	logic       qs_q, qs_nx;
	logic [7:0] e0, e1;
	logic [1:0] n;
	logic [7:0] c;

	assign c = in_byte;

	// Mode and quote-kind registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			qs_q   <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_nx;
			qs_q   <= qs_nx;
		end
	end

	// Classify the byte and collect the bytes it releases
	always_comb begin
		mode_nx = mode_q;
		qs_nx   = qs_q;
		e0      = 8'h00;
		e1      = 8'h00;
		n       = 2'd0;
		unique case (mode_q)
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					mode_nx = MODE_LINE;
				end else if (c == CH_STAR) begin
					mode_nx = MODE_BLOCK;
				end else begin
					// held slash goes out, then the byte as normal text
					e0 = CH_SLASH;
					e1 = c;
					n  = 2'd2;
					if (c == CH_DQ || c == CH_SQ) begin
						qs_nx   = (c == CH_SQ);
						mode_nx = MODE_LIT;
					end else begin
						mode_nx = MODE_NORMAL;
					end
				end
			end
			MODE_LINE: begin
				if (c == CH_NL) begin
					mode_nx = MODE_NORMAL;
					e0      = CH_NL;
					n       = 2'd1;
				end
			end
			MODE_BLOCK, MODE_BSTAR: begin
				if (mode_q == MODE_BSTAR && c == CH_SLASH) begin
					mode_nx = MODE_NORMAL;
				end else if (c == CH_STAR) begin
					mode_nx = MODE_BSTAR;
				end else begin
					mode_nx = MODE_BLOCK;
					if (c == CH_NL) begin
						e0 = CH_NL;
						n  = 2'd1;
					end
				end
			end
			MODE_LIT: begin
				e0 = c;
				n  = 2'd1;
				if (c == CH_BSL)
					mode_nx = MODE_LIT_ESC;
				else if (c == (qs_q ? CH_SQ : CH_DQ))
					mode_nx = MODE_NORMAL;
			end
			MODE_LIT_ESC: begin
				e0      = c;
				n       = 2'd1;
				mode_nx = MODE_LIT;
			end
			default: begin
				if (c == CH_DQ || c == CH_SQ) begin
					qs_nx   = (c == CH_SQ);
					mode_nx = MODE_LIT;
					e0      = c;
					n       = 2'd1;
				end else if (c == CH_SLASH) begin
					mode_nx = MODE_SLASH;
				end else begin
					mode_nx = MODE_NORMAL;
					e0      = c;
					n       = 2'd1;
				end
			end
		endcase

		// End of stream: flush a held slash, back to normal text
		if (in_last) begin
			if (mode_nx == MODE_SLASH) begin
				if (n == 2'd0) begin
					e0 = CH_SLASH;
					n  = 2'd1;
				end else begin
					e1 = CH_SLASH;
					n  = 2'd2;
				end
			end
			mode_nx = MODE_NORMAL;
			qs_nx   = 1'b0;
		end
	end

	// Hand a result group to the queue
	assign grp_push = accept && (n != 2'd0 || in_last);
	assign grp.b0   = e0;
	assign grp.b1   = e1;
	assign grp.two  = (n == 2'd2);
	assign grp.has  = (n != 2'd0);
	assign grp.last = in_last;

endmodule

// ===== rtl/jcs_queue.sv =====
module jcs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  jcs_pkg::grp_t        wdata,
	input  logic                 pop,
	output jcs_pkg::grp_t        rdata,
	output logic                 full,
	output logic                 empty,
	output logic [jcs_pkg::QAW:0] level
);
	import jcs_pkg::*;

	grp_t           mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == QAW'(0) + (QAW+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign level   = cnt_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wdata;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + 1'b1;
			if (do_pop)
				rp_q <= rp_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/jcs_back.sv =====
module jcs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jcs_pkg::grp_t head,
	input  logic          q_empty,
	input  logic          pop,
	output logic          deq,
	output logic [7:0]    out_byte,
	output logic          has_byte,
	output logic          run_last,
	output logic          stream_end
);
	import jcs_pkg::*;

	logic sel_q;
	logic take;

	assign take = pop && !q_empty;

	// Second byte of a pair is pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= 1'b0;
		else if (take)
			sel_q <= head.two && !sel_q;
	end

	// Retire the group after its last result
	assign deq        = take && (!head.two || sel_q);
	assign out_byte   = sel_q ? head.b1 : head.b0;
	assign has_byte   = head.has;
	assign run_last   = !head.two || sel_q;
	assign stream_end = head.last && run_last;

endmodule
